/* rtl/htfd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// htfd_pkg
// Shared types and constants for the humidity/temperature frame decoder.
// ----------------------------------------------------------------------------
package htfd_pkg;

  localparam int unsigned RawW       = 20;
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned TempScale  = 2000;
  localparam int unsigned HumScale   = 1000;
  localparam int unsigned TempOffset = 500;
  localparam int unsigned HumMax     = 999;
  localparam int unsigned TempW      = 12;
  localparam int unsigned HumW       = 10;

  typedef enum logic [1:0] {
    StatusOk   = 2'd0,
    StatusBusy = 2'd1,
    StatusCrc  = 2'd2
  } frame_status_e;

  // One decoded frame handed from the byte front end to the conversion back end
  typedef struct packed {
    frame_status_e    status;
    logic [RawW-1:0]  temp_raw;
    logic [RawW-1:0]  hum_raw;
  } frame_rec_t;

endpackage
`default_nettype wire

/* rtl/htfd_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// htfd_front
// Byte tracker: position count, CRC-8 (0x31), field capture, frame status.
// ----------------------------------------------------------------------------
module htfd_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                accept_i,
  input  wire logic [7:0]          rx_byte_i,
  input  wire logic                frame_start_i,
  output htfd_pkg::frame_rec_t     rec_o,
  output logic                     rec_valid_o
);
  import htfd_pkg::*;

  localparam logic [7:0] CrcInit  = 8'hFF;
  localparam logic [7:0] CrcPoly  = 8'h31;
  localparam logic [2:0] LastByte = 3'd6;

  function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) c = {c[6:0], 1'b0} ^ CrcPoly;
      else      c = {c[6:0], 1'b0};
    end
    return c;
  endfunction

  logic [2:0]      pos_q, pos_d, pos_eff;
  logic [7:0]      crc_q, crc_d, crc_seed;
  logic            busy_q, busy_d;
  logic [RawW-1:0] hum_q, hum_d, temp_q, temp_d;
  logic            last_byte;
  frame_status_e   status;

  // frame start, or a stray count, restarts at byte 0
  assign pos_eff   = (frame_start_i || (pos_q > LastByte)) ? 3'd0 : pos_q;
  assign last_byte = (pos_eff == LastByte);
  assign crc_seed  = (pos_eff == 3'd0) ? CrcInit : crc_q;

  always_comb begin
    if (busy_q)               status = StatusBusy;
    else if (crc_q != rx_byte_i) status = StatusCrc;
    else                      status = StatusOk;
  end

  always_comb begin
    pos_d  = pos_q;
    crc_d  = crc_q;
    busy_d = busy_q;
    hum_d  = hum_q;
    temp_d = temp_q;
    if (accept_i) begin
      if (last_byte) begin
        pos_d = 3'd0;
        crc_d = CrcInit;
      end else begin
        pos_d = pos_eff + 3'd1;
        crc_d = crc_update(crc_seed, rx_byte_i);
        unique case (pos_eff)
          3'd0: busy_d = rx_byte_i[7];
          3'd1: hum_d[19:12] = rx_byte_i;
          3'd2: hum_d[11:4]  = rx_byte_i;
          3'd3: begin
            hum_d[3:0]    = rx_byte_i[7:4];
            temp_d[19:16] = rx_byte_i[3:0];
          end
          3'd4: temp_d[15:8] = rx_byte_i;
          default: temp_d[7:0] = rx_byte_i;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 3'd0;
      crc_q  <= CrcInit;
      busy_q <= 1'b0;
      hum_q  <= '0;
      temp_q <= '0;
    end else begin
      pos_q  <= pos_d;
      crc_q  <= crc_d;
      busy_q <= busy_d;
      hum_q  <= hum_d;
      temp_q <= temp_d;
    end
  end

  assign rec_valid_o    = accept_i && last_byte;
  assign rec_o.status   = status;
  assign rec_o.temp_raw = temp_q;
  assign rec_o.hum_raw  = hum_q;

endmodule
`default_nettype wire

/* rtl/htfd_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// htfd_fifo
// Short frame queue between the byte front end and the conversion back end.
// ----------------------------------------------------------------------------
module htfd_fifo #(
  parameter int unsigned Depth = htfd_pkg::FifoDepth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                wr_i,
  input  htfd_pkg::frame_rec_t     wr_data_i,
  output logic                     full_o,
  input  wire logic                rd_i,
  output htfd_pkg::frame_rec_t     rd_data_o,
  output logic                     empty_o
);
  import htfd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  frame_rec_t      mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wptr_q] <= wr_data_i;
  end

  assign rd_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
      if (do_rd) rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
      unique case ({do_wr, do_rd})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/htfd_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// htfd_back
// Raw-to-tenths conversion: scaling multiply stage, then offset and result register.
// ----------------------------------------------------------------------------
module htfd_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  htfd_pkg::frame_rec_t             in_rec_i,
  output logic                             in_ready_o,
  output logic                             empty_o,
  input  wire logic                        pop_i,
  output logic [1:0]                       frame_status_o,
  output logic signed [htfd_pkg::TempW-1:0] temperature_tenths_o,
  output logic [htfd_pkg::HumW-1:0]        humidity_tenths_o
);
  import htfd_pkg::*;

  localparam int unsigned TProdW = RawW + 11;
  localparam int unsigned HProdW = RawW + HumW;

  logic [TProdW-1:0] t_prod;
  logic [HProdW-1:0] h_prod;

  // stage A: scaled raw values
  logic          a_valid_q;
  frame_status_e a_status_q;
  logic [10:0]   a_tq_q;
  logic [HumW-1:0] a_hq_q;

  // stage B: result register
  logic                   b_valid_q;
  frame_status_e          b_status_q;
  logic signed [TempW-1:0] b_temp_q;
  logic [HumW-1:0]        b_hum_q;

  logic b_ready, a_ready;

  assign b_ready    = !b_valid_q || pop_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  assign t_prod = TProdW'(in_rec_i.temp_raw) * TProdW'(TempScale);
  assign h_prod = HProdW'(in_rec_i.hum_raw) * HProdW'(HumScale);

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_status_q <= in_rec_i.status;
      a_tq_q     <= t_prod[TProdW-1 -: 11];
      a_hq_q     <= h_prod[HProdW-1 -: HumW];
    end
    if (b_ready && a_valid_q) begin
      b_status_q <= a_status_q;
      if (a_status_q == StatusOk) begin
        b_temp_q <= TempW'({1'b0, a_tq_q}) - TempW'(TempOffset);
        b_hum_q  <= a_hq_q;
      end else begin
        b_temp_q <= '0;
        b_hum_q  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= in_valid_i;
      if (b_ready) b_valid_q <= a_valid_q;
    end
  end

  assign empty_o              = !b_valid_q;
  assign frame_status_o       = b_status_q;
  assign temperature_tenths_o = b_temp_q;
  assign humidity_tenths_o    = b_hum_q;

endmodule
`default_nettype wire

/* rtl/humidity_temp_frame_decoder_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder_top
// Sensor response decoder: CRC-8 check, busy flag, temperature/humidity in tenths.
// Throughput: one byte per cycle; full rises only when the frame queue
//   (FifoDepth frames) is full because results are not being popped.
// Path: after its last byte transfer, a frame's result passes the frame queue,
//   the scaling multiply stage and the result register to reach the head.
// Reset: asynchronous, active low; clears byte count, CRC and all queues.
// ----------------------------------------------------------------------------
module humidity_temp_frame_decoder_top #(
  parameter int unsigned FifoDepth = htfd_pkg::FifoDepth
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [7:0]                    rx_byte_i,
  input  wire logic                          frame_start_i,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [1:0]                         frame_status_o,
  output logic signed [htfd_pkg::TempW-1:0]  temperature_tenths_o,
  output logic [htfd_pkg::HumW-1:0]          humidity_tenths_o
);
  import htfd_pkg::*;

  frame_rec_t front_rec, fifo_rec;
  logic       front_valid, fifo_empty, back_ready, accept;

  assign accept = push && !full;

  htfd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .rx_byte_i     (rx_byte_i),
    .frame_start_i (frame_start_i),
    .rec_o         (front_rec),
    .rec_valid_o   (front_valid)
  );

  htfd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (front_valid),
    .wr_data_i (front_rec),
    .full_o    (full),
    .rd_i      (back_ready),
    .rd_data_o (fifo_rec),
    .empty_o   (fifo_empty)
  );

  htfd_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (!fifo_empty),
    .in_rec_i             (fifo_rec),
    .in_ready_o           (back_ready),
    .empty_o              (empty),
    .pop_i                (pop),
    .frame_status_o       (frame_status_o),
    .temperature_tenths_o (temperature_tenths_o),
    .humidity_tenths_o    (humidity_tenths_o)
  );

  // failed frames carry zero readings
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (frame_status_o != StatusOk)) |->
      ((temperature_tenths_o == '0) && (humidity_tenths_o == '0)))
    else $error("failed frame with nonzero reading");

  // good frames stay within the sensor range
  a_ok_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (frame_status_o == StatusOk)) |->
      ((humidity_tenths_o <= HumW'(HumMax)) &&
       (temperature_tenths_o >= -$signed(TempW'(TempOffset)))))
    else $error("converted reading out of range");

  // a head result not popped holds its value
  a_head_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=>
      (!empty && $stable(frame_status_o) && $stable(temperature_tenths_o) &&
       $stable(humidity_tenths_o)))
    else $error("result changed while waiting");

  // queue backpressure only when the queue truly holds frames
  a_full_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !fifo_empty)
    else $error("full with empty frame queue");

endmodule
`default_nettype wire
